// ===== rtl/core/area_image_downscaler_macros.svh =====
// Assertion macros for the area image downscaler checker.
`ifndef AREA_IMAGE_DOWNSCALER_MACROS_SVH
`define AREA_IMAGE_DOWNSCALER_MACROS_SVH

// Consequent checked in the same cycle.
`define ADS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ADS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/core/ads_pkg.sv =====
// Shared types, constants and span functions of the area image downscaler.
`default_nettype none
package ads_pkg;
	localparam int ADS_MAX_WIDTH = 2048;
	localparam int MAX_CHANNELS  = 4;
	localparam int FRAC_BITS     = 16;
	localparam int NUM_REGS      = 7;
	localparam int POS_W         = 40;
	localparam int RATIO_W       = 24;
	localparam int IDX_W         = POS_W - FRAC_BITS;
	localparam int WFIRST_W      = FRAC_BITS + 1;
	localparam int SUM_W         = 64;
	localparam int AREA_W        = 2 * RATIO_W;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 24;

	localparam logic [CFG_IDX_W-1:0] REG_FORMAT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_X    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_RATIO_Y    = 3'd6;

	localparam logic [1:0] FMT_GRAY = 2'd0;
	localparam logic [1:0] FMT_RGB  = 2'd1;

	localparam logic [RATIO_W-1:0] FX_ONE = RATIO_W'(1) << FRAC_BITS;

	typedef struct packed {
		logic [IDX_W-1:0]    first;
		logic [15:0]         last;
		logic [WFIRST_W-1:0] wfirst;
		logic [POS_W-1:0]    wlast;
		logic [IDX_W-1:0]    done;
	} span_t;

	typedef struct packed {
		logic       load;
		logic       span;
		logic       hsum;
		logic       mul;
		logic       tot;
		logic       div;
		logic       out_load;
		logic       upd;
		logic       clr;
		logic [2:0] dig;
		logic [3:0] div_sh;
	} ads_cmd_t;

	typedef struct packed {
		logic col_emit;
		logic fin_y;
		logic row_last;
		logic img_last;
		logic out_free;
	} ads_sts_t;

	function automatic logic [2:0] chan_count(input logic [1:0] fmt);
		logic [2:0] n;
		case (fmt)
			FMT_GRAY: n = 3'd1;
			FMT_RGB:  n = 3'd3;
			default:  n = 3'd4;
		endcase
		return n;
	endfunction

	function automatic span_t span_of(input logic [POS_W-1:0] fin,
			input logic [RATIO_W-1:0] ratio, input logic [15:0] size);
		logic [POS_W-1:0] st;
		logic [IDX_W-1:0] lst;
		span_t s;
		st = (fin >= POS_W'(ratio)) ? fin - POS_W'(ratio) : '0;
		lst = fin[POS_W-1:FRAC_BITS];
		if (fin[FRAC_BITS-1:0] == '0 && lst != '0) begin
			lst = lst - IDX_W'(1);
		end
		if (lst > IDX_W'(size) - IDX_W'(1)) begin
			lst = IDX_W'(size) - IDX_W'(1);
		end
		s.first = st[POS_W-1:FRAC_BITS];
		s.wfirst = WFIRST_W'(FX_ONE) - WFIRST_W'(st[FRAC_BITS-1:0]);
		s.last = lst[15:0];
		s.wlast = (s.first < lst) ? fin - {lst, FRAC_BITS'(0)} : '0;
		s.done = (s.first < lst) ? lst : s.first;
		return s;
	endfunction

	function automatic logic [POS_W-1:0] weight_at(input span_t s, input logic [15:0] i);
		logic [IDX_W-1:0] ii;
		logic [IDX_W-1:0] la;
		logic [POS_W-1:0] w;
		ii = IDX_W'(i);
		la = IDX_W'(s.last);
		if (ii == s.first) begin
			w = POS_W'(s.wfirst);
		end else if (ii > s.first && ii < la) begin
			w = POS_W'(FX_ONE);
		end else if (ii == la && s.first < la) begin
			w = s.wlast;
		end else begin
			w = '0;
		end
		return w;
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/ads_ctrl.sv =====
// Sequencer of the area image downscaler: clear sweep and per-pixel steps.
`default_nettype none
module ads_ctrl import ads_pkg::*; #(
	parameter int MAX_WIDTH = ADS_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_wr,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire ads_sts_t      sts,
	output ads_cmd_t           cmd,
	output logic [AW-1:0]      clr_addr
);
	localparam logic [3:0] ST_CLEAR = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_SPAN  = 4'd2;
	localparam logic [3:0] ST_HSUM  = 4'd3;
	localparam logic [3:0] ST_MUL   = 4'd4;
	localparam logic [3:0] ST_TOT   = 4'd5;
	localparam logic [3:0] ST_DIV   = 4'd6;
	localparam logic [3:0] ST_OUT   = 4'd7;
	localparam logic [3:0] ST_UPD   = 4'd8;
	localparam logic [3:0] MUL_LAST = 4'd4;
	localparam logic [3:0] DIV_LAST = 4'd8;

	logic [3:0]    state_q, state_d;
	logic [3:0]    cnt_q, cnt_d;
	logic [AW-1:0] addr_q, addr_d;

	assign in_ready = (state_q == ST_IDLE);
	assign clr_addr = addr_q;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		addr_d = addr_q;
		cmd = '0;
		cmd.dig = cnt_q[2:0];
		cmd.div_sh = DIV_LAST - cnt_q;
		case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				addr_d = addr_q + AW'(1);
				if (addr_q == AW'(MAX_WIDTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_SPAN;
				end
			end
			ST_SPAN: begin
				cmd.span = 1'b1;
				state_d = ST_HSUM;
			end
			ST_HSUM: begin
				cmd.hsum = 1'b1;
				cnt_d = '0;
				state_d = sts.col_emit ? ST_MUL : ST_UPD;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == MUL_LAST) begin
					state_d = ST_TOT;
				end
			end
			ST_TOT: begin
				cmd.tot = 1'b1;
				cnt_d = '0;
				state_d = sts.fin_y ? ST_DIV : ST_UPD;
			end
			ST_DIV: begin
				cmd.div = 1'b1;
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == DIV_LAST) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				addr_d = '0;
				state_d = (sts.row_last && sts.img_last) ? ST_CLEAR : ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
				addr_d = '0;
			end
		endcase
		if (cfg_wr) begin
			state_d = ST_CLEAR;
			addr_d = '0;
			cmd.load = 1'b0;
			cmd.out_load = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q <= '0;
			addr_q <= '0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			addr_q <= addr_d;
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/ads_datapath.sv =====
// Datapath: registers, position counters, sums, column memory, divider, output.
`default_nettype none
module ads_datapath import ads_pkg::*; #(
	parameter int MAX_WIDTH = ADS_MAX_WIDTH,
	localparam int AW = $clog2(MAX_WIDTH)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic [31:0]           in_data,
	input  wire ads_cmd_t              cmd,
	input  wire logic [AW-1:0]         clr_addr,
	output ads_sts_t                   sts,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [31:0]                out_pix,
	output logic                       out_row_end,
	output logic                       out_image_end
);
	localparam int RW = MAX_CHANNELS * SUM_W;

	logic [1:0]         fmt_q;
	logic [11:0]        inw_reg_q, outw_reg_q;
	logic [15:0]        inh_reg_q, outh_reg_q;
	logic [RATIO_W-1:0] rx_reg_q, ry_reg_q;

	logic [11:0]        inw, outw;
	logic [15:0]        inh, outh;
	logic [RATIO_W-1:0] rx, ry;
	logic [2:0]         nch;

	logic [11:0]        c_q, x_q;
	logic [15:0]        r_q, y_q;
	logic [POS_W-1:0]   sex_q, sey_q;
	logic [SUM_W-1:0]   row_q [MAX_CHANNELS];

	logic [7:0]         pix_q [MAX_CHANNELS];
	span_t              sx_q, sy_q;
	logic [AW-1:0]      col_addr_q;
	logic [SUM_W-1:0]   h_q [MAX_CHANNELS];
	logic [POS_W-1:0]   wy_q;
	logic [WFIRST_W-1:0] wny_q;
	logic               fin_y_q, share_y_q, re_q, ie_q;
	logic [SUM_W-1:0]   prod_y_q [MAX_CHANNELS];
	logic [SUM_W-1:0]   prod_n_q [MAX_CHANNELS];
	logic [SUM_W-1:0]   num_q [MAX_CHANNELS];
	logic [7:0]         quo_q [MAX_CHANNELS];
	logic               sat_q [MAX_CHANNELS];
	logic [AREA_W-1:0]  area_q;

	logic [RW-1:0]      col_mem [MAX_WIDTH];
	logic [RW-1:0]      rd_q;
	logic [RW-1:0]      wr_data;
	logic [AW-1:0]      wr_addr;
	logic               wr_en;

	logic               row_last, img_last, col_done, share_x, x_ok, y_ok;
	logic [POS_W-1:0]   w_x, w_y;
	logic [WFIRST_W-1:0] wn_x;
	logic [15:0]        mul_op;
	logic [5:0]         mul_sh;
	logic [SUM_W-1:0]   tot [MAX_CHANNELS];
	logic [SUM_W-1:0]   div_d;

	logic               out_valid_q, out_row_end_q, out_image_end_q;
	logic [31:0]        out_pix_q;

	always_comb begin
		inw = (inw_reg_q == '0) ? 12'd1 :
			((int'(inw_reg_q) > MAX_WIDTH) ? 12'(MAX_WIDTH) : inw_reg_q);
		outw = (outw_reg_q == '0) ? 12'd1 :
			((int'(outw_reg_q) > MAX_WIDTH) ? 12'(MAX_WIDTH) : outw_reg_q);
		inh = (inh_reg_q == '0) ? 16'd1 : inh_reg_q;
		outh = (outh_reg_q == '0) ? 16'd1 : outh_reg_q;
		rx = (rx_reg_q < FX_ONE) ? FX_ONE : rx_reg_q;
		ry = (ry_reg_q < FX_ONE) ? FX_ONE : ry_reg_q;
		nch = chan_count(fmt_q);
	end

	assign row_last = (c_q >= inw - 12'd1);
	assign img_last = (r_q >= inh - 16'd1);
	assign x_ok = (x_q < outw);
	assign y_ok = (y_q < outh);
	assign col_done = (IDX_W'(c_q) == sx_q.done) || row_last;
	assign share_x = (sex_q[POS_W-1:FRAC_BITS] == IDX_W'(c_q));
	assign wn_x = WFIRST_W'(FX_ONE) - WFIRST_W'(sex_q[FRAC_BITS-1:0]);
	assign w_x = weight_at(sx_q, 16'(c_q));
	assign w_y = weight_at(sy_q, r_q);

	assign sts.col_emit = x_ok && col_done && y_ok;
	assign sts.fin_y = fin_y_q;
	assign sts.row_last = row_last;
	assign sts.img_last = img_last;
	assign sts.out_free = !out_valid_q;

	always_comb begin
		case (cmd.dig)
			3'd0: begin mul_op = wy_q[15:0]; mul_sh = 6'd0; end
			3'd1: begin mul_op = wy_q[31:16]; mul_sh = 6'd16; end
			3'd2: begin mul_op = 16'(wy_q[POS_W-1:32]); mul_sh = 6'd32; end
			3'd3: begin mul_op = wny_q[15:0]; mul_sh = 6'd0; end
			default: begin mul_op = 16'(wny_q[WFIRST_W-1:16]); mul_sh = 6'd16; end
		endcase
		for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
			tot[ch] = rd_q[ch*SUM_W +: SUM_W] + prod_y_q[ch];
		end
		div_d = SUM_W'(area_q) << cmd.div_sh;
		wr_en = cmd.clr || cmd.tot;
		wr_addr = cmd.clr ? clr_addr : col_addr_q;
		for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
			if (cmd.clr) begin
				wr_data[ch*SUM_W +: SUM_W] = '0;
			end else if (fin_y_q) begin
				wr_data[ch*SUM_W +: SUM_W] = share_y_q ? prod_n_q[ch] : '0;
			end else begin
				wr_data[ch*SUM_W +: SUM_W] = tot[ch];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			col_mem[wr_addr] <= wr_data;
		end
		if (cmd.span) begin
			rd_q <= col_mem[AW'(x_q)];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_GRAY;
			inw_reg_q <= 12'd1;
			inh_reg_q <= 16'd1;
			outw_reg_q <= 12'd1;
			outh_reg_q <= 16'd1;
			rx_reg_q <= FX_ONE;
			ry_reg_q <= FX_ONE;
		end else if (cfg_wr) begin
			case (cfg_index)
				REG_FORMAT:     fmt_q <= cfg_data[1:0];
				REG_IN_WIDTH:   inw_reg_q <= cfg_data[11:0];
				REG_IN_HEIGHT:  inh_reg_q <= cfg_data[15:0];
				REG_OUT_WIDTH:  outw_reg_q <= cfg_data[11:0];
				REG_OUT_HEIGHT: outh_reg_q <= cfg_data[15:0];
				REG_RATIO_X:    rx_reg_q <= cfg_data;
				REG_RATIO_Y:    ry_reg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
			x_q <= '0;
			y_q <= '0;
			sex_q <= POS_W'(FX_ONE);
			sey_q <= POS_W'(FX_ONE);
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				row_q[ch] <= '0;
			end
		end else if (cmd.clr) begin
			c_q <= '0;
			r_q <= '0;
			x_q <= '0;
			y_q <= '0;
			sex_q <= POS_W'(rx);
			sey_q <= POS_W'(ry);
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				row_q[ch] <= '0;
			end
		end else if (cmd.hsum) begin
			if (x_ok) begin
				for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
					if (!col_done) begin
						row_q[ch] <= row_q[ch] + SUM_W'(pix_q[ch] * w_x);
					end else begin
						row_q[ch] <= share_x ? SUM_W'(pix_q[ch] * wn_x) : '0;
					end
				end
				if (col_done) begin
					x_q <= x_q + 12'd1;
					sex_q <= sex_q + POS_W'(rx);
				end
			end
		end else if (cmd.upd) begin
			if (row_last) begin
				c_q <= '0;
				x_q <= '0;
				sex_q <= POS_W'(rx);
				for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
					row_q[ch] <= '0;
				end
				if (!img_last) begin
					if (y_ok && IDX_W'(r_q) == sy_q.done) begin
						y_q <= y_q + 16'd1;
						sey_q <= sey_q + POS_W'(ry);
					end
					r_q <= r_q + 16'd1;
				end
			end else begin
				c_q <= c_q + 12'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		area_q <= rx * ry;
		if (cmd.load) begin
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				pix_q[ch] <= (3'(ch) < nch) ? in_data[ch*8 +: 8] : 8'd0;
			end
		end
		if (cmd.span) begin
			sx_q <= span_of(sex_q, rx, 16'(inw));
			sy_q <= span_of(sey_q, ry, inh);
			col_addr_q <= AW'(x_q);
		end
		if (cmd.hsum) begin
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				h_q[ch] <= row_q[ch] + SUM_W'(pix_q[ch] * w_x);
				prod_y_q[ch] <= '0;
				prod_n_q[ch] <= '0;
			end
			wy_q <= w_y;
			wny_q <= WFIRST_W'(FX_ONE) - WFIRST_W'(sey_q[FRAC_BITS-1:0]);
			fin_y_q <= (IDX_W'(r_q) == sy_q.done) || img_last;
			share_y_q <= (sey_q[POS_W-1:FRAC_BITS] == IDX_W'(r_q));
			re_q <= (x_q == outw - 12'd1) || row_last;
			ie_q <= ((x_q == outw - 12'd1) || row_last) &&
				((y_q == outh - 16'd1) || img_last);
		end
		if (cmd.mul) begin
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				if (cmd.dig < 3'd3) begin
					prod_y_q[ch] <= prod_y_q[ch] + (SUM_W'(h_q[ch] * mul_op) << mul_sh);
				end else begin
					prod_n_q[ch] <= prod_n_q[ch] + (SUM_W'(h_q[ch] * mul_op) << mul_sh);
				end
			end
		end
		if (cmd.tot) begin
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				num_q[ch] <= tot[ch] + SUM_W'(area_q >> 1);
				quo_q[ch] <= '0;
			end
		end
		if (cmd.div) begin
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				if (cmd.div_sh == 4'd8) begin
					sat_q[ch] <= (num_q[ch] >= div_d);
				end else if (num_q[ch] >= div_d) begin
					num_q[ch] <= num_q[ch] - div_d;
					quo_q[ch][cmd.div_sh[2:0]] <= 1'b1;
				end
			end
		end
		if (cmd.out_load) begin
			for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
				out_pix_q[ch*8 +: 8] <= (3'(ch) < nch) ? (sat_q[ch] ? 8'hFF : quo_q[ch]) : 8'd0;
			end
			out_row_end_q <= re_q;
			out_image_end_q <= ie_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix = out_pix_q;
	assign out_row_end = out_row_end_q;
	assign out_image_end = out_image_end_q;
endmodule
`default_nettype wire

// ===== rtl/core/area_image_downscaler.sv =====
// Each pixel is loaded, spanned, summed into its row and moves the counters; one feeding a
// column also uses the multiplier and column memory, one ending an output pixel also the
// divider and a free output register. The rate is set by the 16-bit-digit multiplier and
// the bit-serial divider. Reset, any register write or image end clears the column memory
// over MAX_WIDTH addresses, when no pixel is taken; configuration writes are always taken.
// Top level of the area image downscaler.
`default_nettype none
module area_image_downscaler import ads_pkg::*; #(
	parameter int MAX_WIDTH = ADS_MAX_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	input  wire logic [31:0]           s_axis_tdata,  // chan_a, chan_b, chan_c, chan_d
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	output logic [31:0]                m_axis_tdata,  // res_a, res_b, res_c, res_d
	output logic                       m_axis_tlast,  // image_end
	output logic                       m_axis_tuser,  // row_end
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int AW = $clog2(MAX_WIDTH);

	ads_cmd_t      cmd;
	ads_sts_t      sts;
	logic [AW-1:0] clr_addr;
	logic          cfg_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr = cfg_valid && (int'(cfg_index) < NUM_REGS);

	ads_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr   (cfg_wr),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd),
		.clr_addr (clr_addr)
	);

	ads_datapath #(.MAX_WIDTH(MAX_WIDTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr        (cfg_wr),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_data       (s_axis_tdata),
		.cmd           (cmd),
		.clr_addr      (clr_addr),
		.sts           (sts),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_pix       (m_axis_tdata),
		.out_row_end   (m_axis_tuser),
		.out_image_end (m_axis_tlast)
	);
endmodule
`default_nettype wire

// ===== rtl/core/ads_checker.sv =====
// Port-level checker of the area image downscaler and its bind.
`default_nettype none
`include "area_image_downscaler_macros.svh"
module ads_checker import ads_pkg::*; (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  s_axis_tvalid,
	input wire logic                  s_axis_tready,
	input wire logic                  m_axis_tvalid,
	input wire logic                  m_axis_tready,
	input wire logic [31:0]           m_axis_tdata,
	input wire logic                  m_axis_tlast,
	input wire logic                  m_axis_tuser,
	input wire logic                  cfg_valid,
	input wire logic                  cfg_ready,
	input wire logic [CFG_IDX_W-1:0]  cfg_index
);
	// stalled result transaction holds
	`ADS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
	// image end only on a row end
	`ADS_ASSERT_SAME(a_img_row, m_axis_tvalid && m_axis_tlast, m_axis_tuser, "image end without row end")
	// one pixel in flight
	`ADS_ASSERT_NEXT(a_in_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "pixel taken while busy")
	// register write starts the clear sweep
	`ADS_ASSERT_NEXT(a_cfg_clear, cfg_valid && cfg_ready && (int'(cfg_index) < NUM_REGS), !s_axis_tready, "pixel taken during clear")
endmodule

bind area_image_downscaler ads_checker u_ads_checker (.*);
`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking testbench for the area image downscaler: streams images through, predicts every output pixel.
module tb;
	import ads_pkg::*;

	localparam logic [1:0] FMT_RGBA = 2'd2;
	localparam logic [1:0] FMT_ALT  = 2'd3;
	localparam longint unsigned ONE  = 64'd1 << FRAC_BITS;
	localparam longint unsigned MASK = ONE - 64'd1;
	localparam int ONE_I = int'(ONE);
	localparam int LIMIT = 4000000;
	localparam int SETTLE_CYCLES = 60;
	localparam int RANDOM_ITEMS = 320;

	typedef struct {
		longint unsigned first, last, wfirst, wlast, fin;
	} cover_t;

	typedef struct packed {
		logic [31:0] data;
		logic        row_end;
		logic        image_end;
	} pix_out_t;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [31:0]           s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [31:0]           m_axis_tdata;
	logic                  m_axis_tlast;
	logic                  m_axis_tuser;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	area_image_downscaler dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.m_axis_tuser(m_axis_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [23:0]     regv [NUM_REGS];
	longint unsigned col_acc [ADS_MAX_WIDTH*MAX_CHANNELS];
	longint unsigned row_acc [MAX_CHANNELS];
	longint unsigned in_col, in_row, out_col, out_row, edge_x, edge_y;

	string    res_name [MAX_CHANNELS] = '{"res_a", "res_b", "res_c", "res_d"};
	pix_out_t pending[$];
	int       fail_count = 0;
	int       sent = 0;
	int       idle_pct = 30;
	bit       hold_start = 0;
	int       hold_left = 0;
	int       rdy_gap = 0;
	int       cycles = 0;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic longint unsigned eff_ratio(longint unsigned r);
		return r < ONE ? ONE : r;
	endfunction

	function automatic longint unsigned clamp_w(longint unsigned w);
		if (w < 1) return 1;
		if (w > ADS_MAX_WIDTH) return ADS_MAX_WIDTH;
		return w;
	endfunction

	function automatic cover_t cover_of(longint unsigned e, longint unsigned ratio,
			longint unsigned size);
		cover_t s;
		longint unsigned st, lst;
		st = e >= ratio ? e - ratio : 0;
		lst = e >> FRAC_BITS;
		if ((e & MASK) == 0 && lst > 0) lst = lst - 1;
		if (lst > size - 1) lst = size - 1;
		s.first = st >> FRAC_BITS;
		s.wfirst = ONE - (st & MASK);
		s.last = lst;
		s.wlast = (s.first < lst) ? e - (lst << FRAC_BITS) : 0;
		s.fin = (s.first < lst) ? lst : s.first;
		return s;
	endfunction

	function automatic longint unsigned weight_of(cover_t s, longint unsigned i);
		if (i == s.first) return s.wfirst;
		if (i > s.first && i < s.last) return ONE;
		if (i == s.last && s.first < s.last) return s.wlast;
		return 0;
	endfunction

	function automatic void image_restart();
		foreach (col_acc[i]) col_acc[i] = 0;
		foreach (row_acc[i]) row_acc[i] = 0;
		in_col = 0; in_row = 0; out_col = 0; out_row = 0;
		edge_x = eff_ratio(regv[REG_RATIO_X]);
		edge_y = eff_ratio(regv[REG_RATIO_Y]);
	endfunction

	function automatic void model_write(int idx, logic [23:0] v);
		case (idx)
			REG_FORMAT:                   regv[idx] = v & 24'h3;
			REG_IN_WIDTH, REG_OUT_WIDTH:  regv[idx] = v & 24'hFFF;
			REG_IN_HEIGHT, REG_OUT_HEIGHT: regv[idx] = v & 24'hFFFF;
			default:                      regv[idx] = v;
		endcase
		image_restart();
	endfunction

	function automatic void model_pixel(logic [31:0] d);
		int nch;
		longint unsigned inw, inh, outw, outh, rx, ry, c, r, x, y, w, wn, wy, wny;
		longint unsigned area, half, tot, q;
		longint unsigned p [MAX_CHANNELS];
		longint unsigned h [MAX_CHANNELS];
		bit row_last, img_last, share_x, share_y, fin_y, re;
		cover_t sx, sy;
		pix_out_t o;
		nch = regv[REG_FORMAT] == FMT_GRAY ? 1 : (regv[REG_FORMAT] == FMT_RGB ? 3 : 4);
		inw = clamp_w(regv[REG_IN_WIDTH]);
		inh = regv[REG_IN_HEIGHT] == 0 ? 1 : regv[REG_IN_HEIGHT];
		outw = clamp_w(regv[REG_OUT_WIDTH]);
		outh = regv[REG_OUT_HEIGHT] == 0 ? 1 : regv[REG_OUT_HEIGHT];
		rx = eff_ratio(regv[REG_RATIO_X]);
		ry = eff_ratio(regv[REG_RATIO_Y]);
		c = in_col; r = in_row; x = out_col; y = out_row;
		row_last = c >= inw - 1;
		img_last = r >= inh - 1;
		for (int ch = 0; ch < MAX_CHANNELS; ch++)
			p[ch] = ch < nch ? longint'(d[8*ch +: 8]) : 0;
		if (x < outw) begin
			sx = cover_of(edge_x, rx, inw);
			w = weight_of(sx, c);
			for (int ch = 0; ch < MAX_CHANNELS; ch++) h[ch] = row_acc[ch] + p[ch] * w;
			if (c != sx.fin && !row_last) begin
				for (int ch = 0; ch < MAX_CHANNELS; ch++) row_acc[ch] = h[ch];
			end else begin
				share_x = (edge_x >> FRAC_BITS) == c;
				wn = ONE - (edge_x & MASK);
				for (int ch = 0; ch < MAX_CHANNELS; ch++) row_acc[ch] = share_x ? p[ch] * wn : 0;
				if (y < outh) begin
					sy = cover_of(edge_y, ry, inh);
					wy = weight_of(sy, r);
					fin_y = (r == sy.fin) || img_last;
					share_y = (edge_y >> FRAC_BITS) == r;
					wny = ONE - (edge_y & MASK);
					area = rx * ry;
					half = area >> 1;
					o = '0;
					for (int ch = 0; ch < MAX_CHANNELS; ch++) begin
						tot = col_acc[x*MAX_CHANNELS + ch] + h[ch] * wy;
						if (fin_y) begin
							q = (tot + half) / area;
							o.data[8*ch +: 8] = ch < nch ? (q > 255 ? 8'hFF : q[7:0]) : 8'h00;
							col_acc[x*MAX_CHANNELS + ch] = share_y ? h[ch] * wny : 0;
						end else begin
							col_acc[x*MAX_CHANNELS + ch] = tot;
						end
					end
					if (fin_y) begin
						re = (x == outw - 1) || row_last;
						o.row_end = re;
						o.image_end = re && (y == outh - 1 || img_last);
						pending.push_back(o);
					end
				end
				x++;
				edge_x += rx;
			end
		end
		if (row_last) begin
			in_col = 0; out_col = 0; edge_x = rx;
			foreach (row_acc[i]) row_acc[i] = 0;
			if (img_last) begin
				image_restart();
			end else begin
				if (y < outh) begin
					sy = cover_of(edge_y, ry, inh);
					if (r == sy.fin) begin
						out_row = y + 1;
						edge_y += ry;
					end
				end
				in_row = r + 1;
			end
		end else begin
			in_col = c + 1;
			out_col = x;
		end
	endfunction

	function automatic int pick_gap();
		if (idle_pct == 0 || $urandom_range(99) >= idle_pct) return 0;
		if ($urandom_range(9) == 0) return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	task automatic send_pixel(input logic [31:0] d);
		int g;
		s_axis_tdata <= d;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		model_pixel(d);
		sent++;
		g = pick_gap();
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(input logic [1:0] fmt, input int inw, input int inh,
			input int outw, input int outh, input int rx, input int ry);
		logic [23:0] v [NUM_REGS];
		drain();
		v[REG_FORMAT] = 24'(fmt); v[REG_IN_WIDTH] = 24'(inw); v[REG_IN_HEIGHT] = 24'(inh);
		v[REG_OUT_WIDTH] = 24'(outw); v[REG_OUT_HEIGHT] = 24'(outh);
		v[REG_RATIO_X] = 24'(rx); v[REG_RATIO_Y] = 24'(ry);
		for (int i = 0; i < NUM_REGS; i++) begin
			cfg_index <= CFG_IDX_W'(i);
			cfg_data <= v[i];
			cfg_valid <= 1'b1;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			model_write(i, v[i]);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic int ratio_of(int a, int b);
		return (a << FRAC_BITS) / b;
	endfunction

	task automatic send_image(input int n);
		for (int i = 0; i < n; i++) send_pixel($urandom);
	endtask

	task automatic test_identity();
		write_regs(FMT_GRAY, 3, 2, 3, 2, ONE_I, ONE_I);
		send_pixel(32'h0000_0000); send_pixel(32'hFFFF_FFFF); send_pixel(32'h0000_00FF);
		send_pixel(32'hFFFF_FF00); send_pixel(32'h5555_5555); send_pixel(32'hAAAA_AAAA);
	endtask

	task automatic test_formats();
		write_regs(FMT_RGB, 4, 2, 2, 1, ratio_of(4, 2), ratio_of(2, 1));
		send_image(8);
		write_regs(FMT_RGBA, 2, 2, 1, 1, ratio_of(2, 1), ratio_of(2, 1));
		send_pixel(32'hFFFF_FFFF); send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFFFF_FFFF); send_pixel(32'hFFFF_FFFF);
		write_regs(FMT_ALT, 3, 1, 2, 1, ratio_of(3, 2), ONE_I);
		send_image(3);
	endtask

	task automatic test_odd_sizes();
		// zero sizes and ratios saturate, max ratio collapses to one cell
		write_regs(FMT_GRAY, 0, 0, 0, 0, 0, 0);
		send_image(2);
		write_regs(FMT_RGBA, 3, 2, 1, 1, 24'hFFFFFF, 24'hFFFFFF);
		send_image(6);
		// rows end before their cells
		write_regs(FMT_GRAY, 5, 3, 3, 3, ratio_of(3, 1), ratio_of(2, 1));
		send_image(15);
		// cells end before the input does
		write_regs(FMT_RGB, 8, 4, 2, 1, ratio_of(3, 2), ratio_of(3, 2));
		send_image(32);
		// partial image, then a restart by writing the registers
		write_regs(FMT_GRAY, 4, 4, 4, 4, ONE_I, ONE_I);
		send_image(5);
		// widest image, first part of its row
		write_regs(FMT_GRAY, 24'hFFF, 1, 24'hFFF, 1, ratio_of(4095, 4095), ONE_I);
		send_image(160);
	endtask

	task automatic test_random_images();
		int inw, inh, outw, outh, rx, ry, n, start;
		start = sent;
		while (sent - start < RANDOM_ITEMS) begin
			inw = $urandom_range(3) == 0 ? $urandom_range(40, 1) : $urandom_range(12, 1);
			inh = $urandom_range(8, 1);
			outw = $urandom_range(inw, 1);
			outh = $urandom_range(inh, 1);
			rx = ratio_of(inw, outw);
			ry = ratio_of(inh, outh);
			case ($urandom_range(9))
				0: rx = $urandom_range(ONE_I * 3, 0);
				1: ry = $urandom_range(ONE_I * 3, 0);
				2: begin
					outw = $urandom_range(4095);
					outh = $urandom_range(65535);
				end
				default: ;
			endcase
			idle_pct = $urandom_range(4) == 0 ? 0 : 30;
			write_regs(2'($urandom_range(3)), inw, inh, outw, outh, rx, ry);
			n = inw * inh * $urandom_range(2, 1);
			if ($urandom_range(9) == 0) n = $urandom_range(n, 1);
			if (n > RANDOM_ITEMS - (sent - start)) n = RANDOM_ITEMS - (sent - start);
			send_image(n);
		end
		idle_pct = 30;
	endtask

	task automatic test_backpressure();
		write_regs(FMT_RGBA, 8, 6, 8, 6, ONE_I, ONE_I);
		idle_pct = 0;
		hold_start = 1'b1;
		send_image(48);
		idle_pct = 30;
	endtask

	always @(posedge clk) begin
		if (hold_start) begin
			hold_left = 3000;
			hold_start = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else if (rdy_gap > 0) begin
			rdy_gap--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			rdy_gap = pick_gap();
		end
	end

	always @(posedge clk) begin
		pix_out_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending.size() == 0) begin
				$error("unexpected output pixel %h", m_axis_tdata);
				fail_count++;
			end else begin
				e = pending.pop_front();
				for (int ch = 0; ch < MAX_CHANNELS; ch++)
					if (m_axis_tdata[8*ch +: 8] !== e.data[8*ch +: 8]) begin
						$error("%s: expected %0d, got %0d", res_name[ch],
							e.data[8*ch +: 8], m_axis_tdata[8*ch +: 8]);
						fail_count++;
					end
				if (m_axis_tuser !== e.row_end) begin
					$error("row_end: expected %0b, got %0b", e.row_end, m_axis_tuser);
					fail_count++;
				end
				if (m_axis_tlast !== e.image_end) begin
					$error("image_end: expected %0b, got %0b", e.image_end, m_axis_tlast);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		regv[REG_FORMAT] = FMT_GRAY;
		regv[REG_IN_WIDTH] = 1; regv[REG_IN_HEIGHT] = 1;
		regv[REG_OUT_WIDTH] = 1; regv[REG_OUT_HEIGHT] = 1;
		regv[REG_RATIO_X] = 24'(ONE); regv[REG_RATIO_Y] = 24'(ONE);
		image_restart();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_identity();
		test_formats();
		test_odd_sizes();
		test_backpressure();
		test_random_images();
		drain();
		if (pending.size() != 0) fail_count++;
		if (fail_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule
